/* sv/mmpw_pkg.sv */
`default_nettype none
package mmpw_pkg;

  localparam int PRIME_W = 30;
  localparam logic [PRIME_W-1:0] PRIME = 30'd1000000007;
  localparam int NODE_W  = 3;
  localparam int ROW_W   = 5;
  localparam int LEN_W   = 31;
  localparam int CFG_W   = 4;
  localparam int DIGIT_W = 2;
  localparam int DIGITS  = PRIME_W / DIGIT_W;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [3:0] {
    C_NOP, C_CLR, C_BUMP, C_INIT, C_LOADX, C_START, C_STEP, C_ADD, C_WSCR, C_COMMIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     k;
    logic [DIGIT_W-1:0]   digit;
    logic                 sel_acc;
    logic [NODE_W-1:0]    na;
    logic [NODE_W-1:0]    nb;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DECIDE, S_LOADX, S_START, S_MUL, S_ADD, S_WSCR, S_COMMIT, S_DONE
  } state_t;

endpackage
`default_nettype wire

/* sv/mmpw_cell.sv */
`default_nettype none
module mmpw_cell #(
  parameter int MAX_NODES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmpw_pkg::ROW_W-1:0]          col,
  input  mmpw_pkg::cell_cmd_t                 cmd,
  input  logic [mmpw_pkg::PRIME_W-1:0]        xs_in,
  output logic [mmpw_pkg::PRIME_W-1:0]        xs_out,
  output logic [mmpw_pkg::PRIME_W-1:0]        acc_rd
);
  import mmpw_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [32:0] P1 = {3'b000, PRIME};
  localparam logic [32:0] P2 = P1 << 1;
  localparam logic [32:0] P4 = P1 << 2;

  // column col of each matrix
  logic [PRIME_W-1:0] adj_r  [MAX_NODES];
  logic [PRIME_W-1:0] adj_nxt[MAX_NODES];
  logic [PRIME_W-1:0] acc_r  [MAX_NODES];
  logic [PRIME_W-1:0] base_r [MAX_NODES];
  logic [PRIME_W-1:0] scr_r  [MAX_NODES];
  logic [PRIME_W-1:0] xs_r, y_r, prod_r, sum_r;
  logic [PRIME_W-1:0] prod_nxt, sum_nxt;
  logic [IW-1:0]      row, kk;
  logic [32:0]        mv, m1, m2, m3;
  logic [PRIME_W:0]   sv;

  assign row    = cmd.row[IW-1:0];
  assign kk     = cmd.k[IW-1:0];
  assign xs_out = xs_r;
  assign acc_rd = acc_r[row];

  // prod = 4*prod + y*digit mod p
  always_comb begin
    mv = {1'b0, prod_r, 2'b00}
       + (cmd.digit[1] ? {2'b00, y_r, 1'b0} : 33'd0)
       + (cmd.digit[0] ? {3'b000, y_r} : 33'd0);
    m1 = (mv >= P4) ? mv - P4 : mv;
    m2 = (m1 >= P2) ? m1 - P2 : m1;
    m3 = (m2 >= P1) ? m2 - P1 : m2;
    prod_nxt = m3[PRIME_W-1:0];
    sv = {1'b0, sum_r} + {1'b0, prod_r};
    if (sv >= {1'b0, PRIME}) begin
      sv = sv - {1'b0, PRIME};
    end
    sum_nxt = sv[PRIME_W-1:0];
  end

  always_comb begin
    logic [1:0]       inc;
    logic [PRIME_W:0] bv;
    for (int r = 0; r < MAX_NODES; r++) begin
      adj_nxt[r] = adj_r[r];
      inc = 2'd0;
      bv  = '0;
      case (cmd.op)
        C_CLR: begin
          adj_nxt[r] = '0;
        end
        C_BUMP: begin
          inc = 2'((col == {2'b00, cmd.nb}) && (ROW_W'(r) == {2'b00, cmd.na}))
              + 2'((col == {2'b00, cmd.na}) && (ROW_W'(r) == {2'b00, cmd.nb}));
          bv = {1'b0, adj_r[r]} + {29'd0, inc};
          if (bv >= {1'b0, PRIME}) begin
            bv = bv - {1'b0, PRIME};
          end
          adj_nxt[r] = bv[PRIME_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_NODES; r++) adj_r[r] <= '0;
    end else begin
      for (int r = 0; r < MAX_NODES; r++) adj_r[r] <= adj_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_INIT: begin
        for (int r = 0; r < MAX_NODES; r++) begin
          acc_r[r]  <= (ROW_W'(r) == col) ? 30'd1 : 30'd0;
          base_r[r] <= adj_r[r];
        end
      end
      C_LOADX: begin
        xs_r  <= cmd.sel_acc ? acc_r[row] : base_r[row];
        sum_r <= '0;
      end
      C_START: begin
        xs_r   <= xs_in;
        y_r    <= base_r[kk];
        prod_r <= '0;
      end
      C_STEP: prod_r <= prod_nxt;
      C_ADD:  sum_r  <= sum_nxt;
      C_WSCR: scr_r[row] <= sum_r;
      C_COMMIT: begin
        for (int r = 0; r < MAX_NODES; r++) begin
          if (cmd.sel_acc) begin
            acc_r[r] <= scr_r[r];
          end else begin
            base_r[r] <= scr_r[r];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/modular_matrix_power_walk_count.sv */
`default_nettype none
// Walk counter modulo 1000000007: ops clear the adjacency store, add an
// undirected edge (both give no result beat), or return the number of walks
// of length walk_length between two nodes (one result beat). A row of
// MAX_NODES cells each holds one matrix column; row entries shift down the
// chain and each cell runs a 2-bit-per-cycle modular multiplier. A query
// needs one product per set bit of walk_length plus one squaring per bit
// below the top set bit (at most 61). Results wait in an output register
// while the next beat is taken. The user must write node_count only while
// the block is idle; the block itself does not enforce it.
module modular_matrix_power_walk_count #(
  parameter int MAX_NODES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [mmpw_pkg::NODE_W-1:0]    in_node_a,
  input  logic [mmpw_pkg::NODE_W-1:0]    in_node_b,
  input  logic [mmpw_pkg::LEN_W-1:0]     in_walk_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mmpw_pkg::PRIME_W-1:0]   out_walk_count,
  input  logic                           cfg_we,
  input  logic [mmpw_pkg::CFG_W-1:0]     cfg_wdata
);
  import mmpw_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);

  state_t             state_r, state_nxt;
  cell_cmd_t          cmd;
  logic [CFG_W-1:0]   cfg_r;
  logic [NODE_W-1:0]  na_r, nb_r;
  logic [LEN_W-1:0]   exp_r;
  logic [NW-1:0]      n_r, n_eff;
  logic [IW-1:0]      row_r, k_r, nb_idx;
  logic [3:0]         dc_r;
  logic [PRIME_W-1:0] xreg_r;
  logic               sel_r;
  logic               out_valid_r;
  logic [PRIME_W-1:0] out_data_r;
  logic               accept, last_k, last_row, out_free, hit;
  logic [PRIME_W-1:0] xs_chain [MAX_NODES+1];
  logic [PRIME_W-1:0] acc_rd   [MAX_NODES];

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign last_k   = (NW'(k_r) == n_r - NW'(1));
  assign last_row = (NW'(row_r) == n_r - NW'(1));
  assign out_free = !out_valid_r || out_ready;
  assign nb_idx   = IW'(nb_r);
  assign hit      = (int'(na_r) < int'(n_r)) && (int'(nb_r) < int'(n_r));
  assign out_valid      = out_valid_r;
  assign out_walk_count = out_data_r;

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(cfg_r) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(cfg_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept && in_op == OP_QUERY) state_nxt = S_INIT;
      S_INIT:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (exp_r == '0) ? S_DONE : S_LOADX;
      S_LOADX:  state_nxt = S_START;
      S_START:  state_nxt = S_MUL;
      S_MUL:    if (dc_r == 4'(DIGITS - 1)) state_nxt = S_ADD;
      S_ADD:    state_nxt = last_k ? S_WSCR : S_START;
      S_WSCR:   state_nxt = last_row ? S_COMMIT : S_LOADX;
      S_COMMIT: state_nxt = S_DECIDE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = C_NOP;
    cmd.row     = ROW_W'(row_r);
    cmd.k       = ROW_W'(k_r);
    cmd.digit   = xreg_r[PRIME_W-1 -: DIGIT_W];
    cmd.sel_acc = sel_r;
    cmd.na      = in_node_a;
    cmd.nb      = in_node_b;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_CLEAR) begin
          cmd.op = C_CLR;
        end else if (accept && in_op == OP_EDGE && int'(in_node_a) < MAX_NODES
                     && int'(in_node_b) < MAX_NODES) begin
          cmd.op = C_BUMP;
        end
      end
      S_INIT:   cmd.op = C_INIT;
      S_LOADX:  cmd.op = C_LOADX;
      S_START:  cmd.op = C_START;
      S_MUL:    cmd.op = C_STEP;
      S_ADD:    cmd.op = C_ADD;
      S_WSCR:   cmd.op = C_WSCR;
      S_COMMIT: cmd.op = C_COMMIT;
      S_DONE:   cmd.row = ROW_W'(na_r);
      default:  cmd.op = C_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          na_r  <= in_node_a;
          nb_r  <= in_node_b;
          exp_r <= in_walk_length;
          n_r   <= n_eff;
        end
      end
      S_DECIDE: begin
        sel_r <= exp_r[0];
        row_r <= '0;
      end
      S_LOADX: k_r <= '0;
      S_START: begin
        xreg_r <= xs_chain[0];
        dc_r   <= '0;
      end
      S_MUL: begin
        xreg_r <= xreg_r << DIGIT_W;
        dc_r   <= dc_r + 4'd1;
      end
      S_ADD:    if (!last_k) k_r <= k_r + IW'(1);
      S_WSCR:   if (!last_row) row_r <= row_r + IW'(1);
      S_COMMIT: exp_r <= sel_r ? exp_r - LEN_W'(1) : exp_r >> 1;
      S_DONE:   if (out_free) out_data_r <= hit ? acc_rd[nb_idx] : '0;
      default: ;
    endcase
  end

  assign xs_chain[MAX_NODES] = '0;

  for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
    mmpw_cell #(
      .MAX_NODES(MAX_NODES)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .col   (ROW_W'(j)),
      .cmd   (cmd),
      .xs_in (xs_chain[j+1]),
      .xs_out(xs_chain[j]),
      .acc_rd(acc_rd[j])
    );
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mmpw_pkg::*;

  localparam int NODES = 8;
  localparam logic [63:0] P = 64'd1000000007;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = OP_CLEAR;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic [LEN_W-1:0] in_walk_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRIME_W-1:0] out_walk_count;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  modular_matrix_power_walk_count #(.MAX_NODES(NODES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_node_a(in_node_a), .in_node_b(in_node_b), .in_walk_length(in_walk_length),
    .out_valid(out_valid), .out_ready(out_ready), .out_walk_count(out_walk_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #500_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  logic [63:0] adj [NODES][NODES];
  logic [CFG_W-1:0] node_cfg = 4'd8;
  logic [PRIME_W-1:0] count_queue [$];
  int errors = 0;
  bit random_phase = 0;

  function automatic int active_nodes();
    if (node_cfg == 0) return 1;
    if (node_cfg > NODES) return NODES;
    return node_cfg;
  endfunction

  function automatic logic [PRIME_W-1:0] count_walks(int a, int b, logic [LEN_W-1:0] len);
    logic [63:0] acc [NODES][NODES];
    logic [63:0] base [NODES][NODES];
    logic [63:0] tmp [NODES][NODES];
    logic [63:0] sum;
    int n;
    logic [LEN_W-1:0] e;
    n = active_nodes();
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++) begin
        acc[r][c] = (r == c) ? 64'd1 : 64'd0;
        base[r][c] = adj[r][c];
      end
    e = len;
    while (e != 0) begin
      if (e[0]) begin
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) begin
            sum = 0;
            for (int k = 0; k < n; k++) sum = (sum + (acc[r][k] * base[k][c]) % P) % P;
            tmp[r][c] = sum;
          end
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) acc[r][c] = tmp[r][c];
      end
      e = e >> 1;
      if (e != 0) begin
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) begin
            sum = 0;
            for (int k = 0; k < n; k++) sum = (sum + (base[r][k] * base[k][c]) % P) % P;
            tmp[r][c] = sum;
          end
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) base[r][c] = tmp[r][c];
      end
    end
    if (a < n && b < n) return acc[a][b][PRIME_W-1:0];
    return '0;
  endfunction

  // update the adjacency copy for an accepted beat; returns 1 if a count is due
  function automatic bit apply_beat(logic [1:0] op, int a, int b, logic [LEN_W-1:0] len,
                                    output logic [PRIME_W-1:0] walks);
    walks = '0;
    case (op)
      OP_CLEAR: begin
        for (int r = 0; r < NODES; r++)
          for (int c = 0; c < NODES; c++) adj[r][c] = 0;
        return 0;
      end
      OP_EDGE: begin
        adj[a][b] = (adj[a][b] + 1) % P;
        adj[b][a] = (adj[b][a] + 1) % P;
        return 0;
      end
      OP_QUERY: begin
        walks = count_walks(a, b, len);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_beat(logic [1:0] op, logic [2:0] a, logic [2:0] b,
                           logic [LEN_W-1:0] len, bit has_exp, logic [PRIME_W-1:0] exp_count);
    logic [PRIME_W-1:0] walks;
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_node_a <= a;
    in_node_b <= b;
    in_walk_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_beat(op, a, b, len, walks)) count_queue.push_back(has_exp ? exp_count : walks);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (count_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_nodes(logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cfg = v;
  endtask

  // receiver: stall pattern in windows, plus one long hold-off
  int window = 0;
  int mode = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (random_phase && !hold_done) begin
      hold_done <= 1;
      hold_left <= 20000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (window == 0) mode = $urandom_range(0, 2);
      window <= (window + 1) % 50;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (count_queue.size() == 0) begin
        $error("unexpected result beat: walk_count %0d", out_walk_count);
        errors++;
      end else begin
        if (out_walk_count !== count_queue[0]) begin
          $error("walk_count expected %0d actual %0d", count_queue[0], out_walk_count);
          errors++;
        end
        void'(count_queue.pop_front());
      end
    end
  end

  typedef struct {
    logic [1:0] op;
    logic [2:0] a;
    logic [2:0] b;
    logic [LEN_W-1:0] len;
    bit has_exp;
    logic [PRIME_W-1:0] exp_count;
  } row_t;

  row_t directed [] = '{
    '{OP_QUERY, 3'd0, 3'd0, 31'd0, 1, 30'd1},
    '{OP_QUERY, 3'd0, 3'd1, 31'd0, 1, 30'd0},
    '{OP_QUERY, 3'd7, 3'd7, 31'd0, 1, 30'd1},
    '{OP_QUERY, 3'd0, 3'd0, 31'd5, 1, 30'd0},
    '{OP_EDGE,  3'd0, 3'd1, 31'd0, 0, 30'd0},
    '{OP_EDGE,  3'd1, 3'd1, 31'h7FFFFFFF, 0, 30'd0},
    '{OP_EDGE,  3'd7, 3'd7, 31'd0, 0, 30'd0},
    '{OP_QUERY, 3'd0, 3'd1, 31'd1, 1, 30'd1},
    '{OP_QUERY, 3'd1, 3'd1, 31'd1, 1, 30'd2},
    '{OP_QUERY, 3'd0, 3'd0, 31'd2, 1, 30'd1},
    '{OP_QUERY, 3'd7, 3'd7, 31'd3, 1, 30'd8},
    '{OP_QUERY, 3'd7, 3'd7, 31'd30, 0, 30'd0},
    '{OP_QUERY, 3'd0, 3'd1, 31'h7FFFFFFF, 0, 30'd0},
    '{OP_UNUSED, 3'd7, 3'd7, 31'h7FFFFFFF, 0, 30'd0},
    '{OP_EDGE,  3'd2, 3'd6, 31'd0, 0, 30'd0},
    '{OP_QUERY, 3'd1, 3'd0, 31'd7, 0, 30'd0},
    '{OP_CLEAR, 3'd0, 3'd0, 31'd0, 0, 30'd0},
    '{OP_QUERY, 3'd1, 3'd1, 31'd1, 1, 30'd0},
    '{OP_QUERY, 3'd6, 3'd6, 31'd0, 1, 30'd1}
  };

  logic [CFG_W-1:0] phases [] = '{4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};

  initial begin
    logic [1:0] op;
    logic [LEN_W-1:0] len;
    int pick;
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++) adj[r][c] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_beat(directed[i].op, directed[i].a, directed[i].b, directed[i].len,
                directed[i].has_exp, directed[i].exp_count);
    wait_idle();
    random_phase = 1;
    foreach (phases[p]) begin
      write_nodes(phases[p]);
      for (int i = 0; i < 14; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_EDGE;
        else if (pick < 85) op = OP_QUERY;
        else if (pick < 93) op = OP_CLEAR;
        else op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (op != OP_QUERY) len = {$urandom} & 31'h7FFFFFFF;
        else if (pick < 70) len = $urandom_range(0, 20);
        else if (pick < 92) len = $urandom_range(0, 1000);
        else len = {$urandom} & 31'h7FFFFFFF;
        send_beat(op, $urandom_range(0, 7), $urandom_range(0, 7), len, 0, '0);
      end
      wait_idle();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
